### rtl/core/staggered_grid_coeff_stencil_top_macros.svh
`ifndef STAGGERED_GRID_COEFF_STENCIL_TOP_MACROS_SVH
`define STAGGERED_GRID_COEFF_STENCIL_TOP_MACROS_SVH

// same-cycle implication
`define SGCS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgcs check failed");

// next-cycle implication
`define SGCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgcs check failed");

`endif

### rtl/core/sgcs_pkg.sv
`default_nettype none

package sgcs_pkg;

   localparam int COORD_W    = 6;
   localparam int GRID_W     = 7;
   localparam int SCALE_W    = 16;
   localparam int OUT_W      = SCALE_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_X = 64;
   localparam int MAX_Y = 64;
   localparam int MAX_Z = 64;

   localparam int MASK_DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int MASK_AW    = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;

   localparam int MAX_XY  = (MAX_X > MAX_Y) ? MAX_X : MAX_Y;
   localparam int MAX_XYZ = (MAX_XY > MAX_Z) ? MAX_XY : MAX_Z;
   localparam int EXT_BITS = $clog2(MAX_XYZ + 1);
   localparam int EXT_W   = (EXT_BITS > GRID_W) ? EXT_BITS : GRID_W;

   localparam int N_CELLS = 7;
   localparam int STEP_W  = 3;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(N_CELLS - 1);

   localparam int CELL_C   = 0;
   localparam int CELL_XM  = 1;
   localparam int CELL_YM  = 2;
   localparam int CELL_ZM  = 3;
   localparam int CELL_XYM = 4;
   localparam int CELL_XZM = 5;
   localparam int CELL_YZM = 6;

   // {lower x, lower y, lower z} for each fetch step
   localparam logic [2:0] NEIGHBOR_SEL [N_CELLS] =
      '{3'b000, 3'b100, 3'b010, 3'b001, 3'b110, 3'b101, 3'b011};

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic BOUNDARY_FREE  = 1'b0;
   localparam logic BOUNDARY_FIXED = 1'b1;

   localparam logic [1:0] FACTOR_ZERO = 2'd0;
   localparam logic [1:0] FACTOR_ONE  = 2'd1;
   localparam logic [1:0] FACTOR_TWO  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDARY_KIND  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Z         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHEAR_SCALE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BUOYANCY_SCALE = 3'd5;

   typedef struct packed {
      logic               boundary_kind;
      logic [GRID_W-1:0]  grid_x;
      logic [GRID_W-1:0]  grid_y;
      logic [GRID_W-1:0]  grid_z;
      logic [SCALE_W-1:0] shear_scale;
      logic [SCALE_W-1:0] buoyancy_scale;
   } sgcs_cfg_type;

   typedef struct packed {
      logic               load;
      logic               zero;
      logic [N_CELLS-1:0] cells;
   } sgcs_result_type;

   function automatic logic [EXT_W-1:0] grid_extent(input logic [GRID_W-1:0] g,
                                                    input int maxv);
      if (g == '0 || int'(g) > maxv) begin
         return EXT_W'(maxv);
      end
      return EXT_W'(g);
   endfunction

   function automatic logic [MASK_AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [COORD_W-1:0] z);
      return MASK_AW'((int'(x) * MAX_Y + int'(y)) * MAX_Z + int'(z));
   endfunction

   function automatic logic [1:0] shear_factor(input logic kind, input logic [2:0] s);
      if (kind == BOUNDARY_FIXED) begin
         if (s >= 3'd3) return FACTOR_ONE;
         if (s == 3'd2) return FACTOR_TWO;
         return FACTOR_ZERO;
      end
      return (s == 3'd4) ? FACTOR_ONE : FACTOR_ZERO;
   endfunction

   function automatic logic [1:0] buoy_factor(input logic kind, input logic a,
                                              input logic b);
      logic [1:0] p;
      p = {1'b0, a} + {1'b0, b};
      if (p == 2'd2) return FACTOR_ONE;
      if (kind == BOUNDARY_FREE && p == 2'd1) return FACTOR_TWO;
      return FACTOR_ZERO;
   endfunction

   function automatic logic [OUT_W-1:0] scale_by(input logic [1:0] f,
                                                 input logic [SCALE_W-1:0] s);
      case (f)
         FACTOR_ONE: return {1'b0, s};
         FACTOR_TWO: return {s, 1'b0};
         default:    return '0;
      endcase
   endfunction

endpackage

`default_nettype wire

### rtl/core/sgcs_mask_ram.sv
`default_nettype none

module sgcs_mask_ram #(
   parameter int DEPTH  = 262144,
   parameter int ADDR_W = 18
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic              wdata,
   output logic                   rdata
);

   logic mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/sgcs_seq.sv
`default_nettype none

`include "staggered_grid_coeff_stencil_top_macros.svh"

module sgcs_seq (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sgcs_pkg::sgcs_cfg_type          cfg,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_mode,
   input  wire logic [sgcs_pkg::COORD_W-1:0]    req_cell_x,
   input  wire logic [sgcs_pkg::COORD_W-1:0]    req_cell_y,
   input  wire logic [sgcs_pkg::COORD_W-1:0]    req_cell_z,
   input  wire logic                            req_solid,
   output logic                                 ram_en,
   output logic                                 ram_we,
   output logic [sgcs_pkg::MASK_AW-1:0]         ram_addr,
   output logic                                 ram_wdata,
   input  wire logic                            ram_rdata,
   input  wire logic                            slot_free,
   output sgcs_pkg::sgcs_result_type            res
);
   import sgcs_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_DRAIN, ST_DONE} state_type;

   state_type            state_ff, state_in;
   logic [COORD_W-1:0]   x_ff, y_ff, z_ff, xm_ff, ym_ff, zm_ff;
   logic [COORD_W-1:0]   x_in, y_in, z_in, xm_in, ym_in, zm_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [STEP_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [N_CELLS-1:0]   cells_ff, cells_in;
   logic                 zero_ff, zero_in;

   logic [EXT_W-1:0]     nx, ny, nz, nx_m1, ny_m1, nz_m1;
   logic                 accept, in_grid, in_storage;
   logic [2:0]           sel;
   logic [COORD_W-1:0]   ax, ay, az;

   assign nx    = grid_extent(cfg.grid_x, MAX_X);
   assign ny    = grid_extent(cfg.grid_y, MAX_Y);
   assign nz    = grid_extent(cfg.grid_z, MAX_Z);
   assign nx_m1 = nx - EXT_W'(1);
   assign ny_m1 = ny - EXT_W'(1);
   assign nz_m1 = nz - EXT_W'(1);

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign in_grid    = (EXT_W'(req_cell_x) < nx) && (EXT_W'(req_cell_y) < ny) &&
                       (EXT_W'(req_cell_z) < nz);
   assign in_storage = (int'(req_cell_x) < MAX_X) && (int'(req_cell_y) < MAX_Y) &&
                       (int'(req_cell_z) < MAX_Z);

   assign sel = NEIGHBOR_SEL[step_ff];
   assign ax  = sel[2] ? xm_ff : x_ff;
   assign ay  = sel[1] ? ym_ff : y_ff;
   assign az  = sel[0] ? zm_ff : z_ff;

   assign ram_we    = accept && (req_mode == MODE_LOAD) && in_storage;
   assign ram_en    = ram_we || (state_ff == ST_FETCH);
   assign ram_wdata = req_solid;
   assign ram_addr  = (state_ff == ST_IDLE) ? cell_addr(req_cell_x, req_cell_y, req_cell_z)
                                            : cell_addr(ax, ay, az);

   assign res.load  = (state_ff == ST_DONE) && slot_free;
   assign res.zero  = zero_ff;
   assign res.cells = cells_ff;

   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      xm_in      = xm_ff;
      ym_in      = ym_ff;
      zm_in      = zm_ff;
      step_in    = step_ff;
      zero_in    = zero_ff;
      cells_in   = cells_ff;
      rd_pend_in = 1'b0;
      rd_idx_in  = step_ff;

      if (rd_pend_ff) begin
         cells_in[rd_idx_ff] = ram_rdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_QUERY) begin
               x_in    = req_cell_x;
               y_in    = req_cell_y;
               z_in    = req_cell_z;
               xm_in   = (req_cell_x == '0) ? nx_m1[COORD_W-1:0] : req_cell_x - 1'b1;
               ym_in   = (req_cell_y == '0) ? ny_m1[COORD_W-1:0] : req_cell_y - 1'b1;
               zm_in   = (req_cell_z == '0) ? nz_m1[COORD_W-1:0] : req_cell_z - 1'b1;
               step_in = '0;
               zero_in = !in_grid;
               state_in = in_grid ? ST_FETCH : ST_DONE;
            end
         end
         ST_FETCH: begin
            rd_pend_in = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      xm_ff     <= xm_in;
      ym_ff     <= ym_in;
      zm_ff     <= zm_in;
      step_ff   <= step_in;
      rd_idx_ff <= rd_idx_in;
      cells_ff  <= cells_in;
      zero_ff   <= zero_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   `SGCS_ASSERT_IMPLIES(a_write_only_idle, clock, reset, ram_we, state_ff == ST_IDLE)
   `SGCS_ASSERT_NEXT(a_fetch_returns_data, clock, reset, state_ff == ST_FETCH, rd_pend_ff)

endmodule

`default_nettype wire

### rtl/core/sgcs_coeff.sv
`default_nettype none

`include "staggered_grid_coeff_stencil_top_macros.svh"

module sgcs_coeff (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sgcs_pkg::sgcs_cfg_type        cfg,
   input  wire sgcs_pkg::sgcs_result_type     res,
   output logic                               slot_free,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [sgcs_pkg::OUT_W-1:0]         rsp_mu_yz,
   output logic [sgcs_pkg::OUT_W-1:0]         rsp_mu_xz,
   output logic [sgcs_pkg::OUT_W-1:0]         rsp_mu_xy,
   output logic [sgcs_pkg::OUT_W-1:0]         rsp_buoy_x,
   output logic [sgcs_pkg::OUT_W-1:0]         rsp_buoy_y,
   output logic [sgcs_pkg::OUT_W-1:0]         rsp_buoy_z
);
   import sgcs_pkg::*;

   logic               rsp_valid_ff;
   logic [OUT_W-1:0]   mu_yz_ff, mu_xz_ff, mu_xy_ff, buoy_x_ff, buoy_y_ff, buoy_z_ff;
   logic [OUT_W-1:0]   mu_yz_in, mu_xz_in, mu_xy_in, buoy_x_in, buoy_y_in, buoy_z_in;
   logic [2:0]         sum_yz, sum_xz, sum_xy;
   logic               c;

   assign c = res.cells[CELL_C];

   assign sum_yz = 3'(c) + 3'(res.cells[CELL_YM]) + 3'(res.cells[CELL_ZM]) +
                   3'(res.cells[CELL_YZM]);
   assign sum_xz = 3'(c) + 3'(res.cells[CELL_XM]) + 3'(res.cells[CELL_ZM]) +
                   3'(res.cells[CELL_XZM]);
   assign sum_xy = 3'(c) + 3'(res.cells[CELL_XM]) + 3'(res.cells[CELL_YM]) +
                   3'(res.cells[CELL_XYM]);

   always_comb begin
      if (res.zero) begin
         mu_yz_in  = '0;
         mu_xz_in  = '0;
         mu_xy_in  = '0;
         buoy_x_in = '0;
         buoy_y_in = '0;
         buoy_z_in = '0;
      end else begin
         mu_yz_in  = scale_by(shear_factor(cfg.boundary_kind, sum_yz), cfg.shear_scale);
         mu_xz_in  = scale_by(shear_factor(cfg.boundary_kind, sum_xz), cfg.shear_scale);
         mu_xy_in  = scale_by(shear_factor(cfg.boundary_kind, sum_xy), cfg.shear_scale);
         buoy_x_in = scale_by(buoy_factor(cfg.boundary_kind, c, res.cells[CELL_XM]),
                              cfg.buoyancy_scale);
         buoy_y_in = scale_by(buoy_factor(cfg.boundary_kind, c, res.cells[CELL_YM]),
                              cfg.buoyancy_scale);
         buoy_z_in = scale_by(buoy_factor(cfg.boundary_kind, c, res.cells[CELL_ZM]),
                              cfg.buoyancy_scale);
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (res.load) begin
         mu_yz_ff  <= mu_yz_in;
         mu_xz_ff  <= mu_xz_in;
         mu_xy_ff  <= mu_xy_in;
         buoy_x_ff <= buoy_x_in;
         buoy_y_ff <= buoy_y_in;
         buoy_z_ff <= buoy_z_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_mu_yz  = mu_yz_ff;
   assign rsp_mu_xz  = mu_xz_ff;
   assign rsp_mu_xy  = mu_xy_ff;
   assign rsp_buoy_x = buoy_x_ff;
   assign rsp_buoy_y = buoy_y_ff;
   assign rsp_buoy_z = buoy_z_ff;

   `SGCS_ASSERT_IMPLIES(a_load_into_free_slot, clock, reset, res.load, slot_free)
   `SGCS_ASSERT_NEXT(a_load_sets_valid, clock, reset, res.load, rsp_valid_ff)

endmodule

`default_nettype wire

### rtl/core/staggered_grid_coeff_stencil_top.sv
// Staggered-grid coefficient stencil over a 3D solid/void mask held in one
// single-port memory of MAX_X*MAX_Y*MAX_Z bits. A load request writes one mask
// bit. A query request returns six Q9.8 coefficients: the cell and its six lower
// neighbours (periodic within the active grid) are read one per cycle through
// the single memory port, then a drain state takes the last read and a done
// state hands the result to the output register once that register is free.
// A query outside the active grid skips the memory and goes to the done state. The
// result register lets the next request enter while a result waits. The mask
// is not cleared after reset; a query must only touch cells already loaded.
// Configuration writes are accepted at any time but must be issued while idle.
`default_nettype none

module staggered_grid_coeff_stencil_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sgcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sgcs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_mode,
   input  wire logic [sgcs_pkg::COORD_W-1:0]      req_cell_x,
   input  wire logic [sgcs_pkg::COORD_W-1:0]      req_cell_y,
   input  wire logic [sgcs_pkg::COORD_W-1:0]      req_cell_z,
   input  wire logic                              req_solid,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [sgcs_pkg::OUT_W-1:0]             rsp_mu_yz,
   output logic [sgcs_pkg::OUT_W-1:0]             rsp_mu_xz,
   output logic [sgcs_pkg::OUT_W-1:0]             rsp_mu_xy,
   output logic [sgcs_pkg::OUT_W-1:0]             rsp_buoy_x,
   output logic [sgcs_pkg::OUT_W-1:0]             rsp_buoy_y,
   output logic [sgcs_pkg::OUT_W-1:0]             rsp_buoy_z
);
   import sgcs_pkg::*;

   sgcs_cfg_type        cfg_ff;
   sgcs_result_type     res;
   logic                slot_free;
   logic                ram_en, ram_we, ram_wdata, ram_rdata;
   logic [MASK_AW-1:0]  ram_addr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boundary_kind  <= BOUNDARY_FREE;
         cfg_ff.grid_x         <= GRID_W'(64);
         cfg_ff.grid_y         <= GRID_W'(64);
         cfg_ff.grid_z         <= GRID_W'(64);
         cfg_ff.shear_scale    <= SCALE_W'(256);
         cfg_ff.buoyancy_scale <= SCALE_W'(256);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOUNDARY_KIND:  cfg_ff.boundary_kind  <= csr_wdata[0];
            CSR_GRID_X:         cfg_ff.grid_x         <= csr_wdata[GRID_W-1:0];
            CSR_GRID_Y:         cfg_ff.grid_y         <= csr_wdata[GRID_W-1:0];
            CSR_GRID_Z:         cfg_ff.grid_z         <= csr_wdata[GRID_W-1:0];
            CSR_SHEAR_SCALE:    cfg_ff.shear_scale    <= csr_wdata[SCALE_W-1:0];
            CSR_BUOYANCY_SCALE: cfg_ff.buoyancy_scale <= csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sgcs_mask_ram #(
      .DEPTH  (MASK_DEPTH),
      .ADDR_W (MASK_AW)
   ) u_mask_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   sgcs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_cell_x (req_cell_x),
      .req_cell_y (req_cell_y),
      .req_cell_z (req_cell_z),
      .req_solid  (req_solid),
      .ram_en     (ram_en),
      .ram_we     (ram_we),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .ram_rdata  (ram_rdata),
      .slot_free  (slot_free),
      .res        (res)
   );

   sgcs_coeff u_coeff (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .res        (res),
      .slot_free  (slot_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_mu_yz  (rsp_mu_yz),
      .rsp_mu_xz  (rsp_mu_xz),
      .rsp_mu_xy  (rsp_mu_xy),
      .rsp_buoy_x (rsp_buoy_x),
      .rsp_buoy_y (rsp_buoy_y),
      .rsp_buoy_z (rsp_buoy_z)
   );

endmodule

`default_nettype wire
